/* rtl/core/lst_pkg.sv */
// Shared types, character codes and keyword helper for the source tokenizer.
package lst_pkg;

    // Token kinds as they leave the block
    typedef enum logic [3:0] {
        TK_LAMBDA   = 4'd0,
        TK_EQUAL    = 4'd1,
        TK_OP       = 4'd2,
        TK_IF       = 4'd3,
        TK_THEN     = 4'd4,
        TK_ELSE     = 4'd5,
        TK_BOOL     = 4'd6,
        TK_VARIABLE = 4'd7,
        TK_NAT      = 4'd8,
        TK_INVALID  = 4'd9,
        TK_EOF      = 4'd10
    } token_kind_t;

    // Scanner mode between bytes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_BAD  = 2'd3
    } scan_mode_t;

    // Single-character token codes
    localparam logic [7:0] CH_LAMBDA = 8'h5C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Keyword prefixes, first byte in the low byte
    localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
    localparam logic [39:0] KW_THEN  = 40'h00_6E65_6874;
    localparam logic [39:0] KW_ELSE  = 40'h00_6573_6C65;
    localparam logic [39:0] KW_TRUE  = 40'h00_6575_7274;
    localparam logic [39:0] KW_FALSE = 40'h65_736C_6166;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Input transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } src_byte_t;

    // Token without the run marker
    typedef struct packed {
        token_kind_t token_kind;
        logic [23:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  op_char;
    } tok_body_t;

    // Output transaction
    typedef struct packed {
        token_kind_t token_kind;
        logic [23:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  op_char;
        logic        run_last;
    } token_t;

    // All tokens caused by one byte: flushed open token, middle token, eof
    typedef struct packed {
        logic        a_vld;
        tok_body_t   a;
        logic        m_vld;
        tok_body_t   m;
        logic        e_vld;
        logic [23:0] e_start;
    } rec_t;

    // Classify a finished word from its length and stored prefix
    function automatic token_kind_t word_kind(input logic [15:0] len,
                                              input logic [39:0] pre);
        token_kind_t k;
        k = TK_VARIABLE;
        if (len == 16'd2 && pre == KW_IF) begin
            k = TK_IF;
        end
        else if (len == 16'd4 && pre == KW_THEN) begin
            k = TK_THEN;
        end
        else if (len == 16'd4 && pre == KW_ELSE) begin
            k = TK_ELSE;
        end
        else if (len == 16'd4 && pre == KW_TRUE) begin
            k = TK_BOOL;
        end
        else if (len == 16'd5 && pre == KW_FALSE) begin
            k = TK_BOOL;
        end
        return k;
    endfunction

endpackage

/* rtl/core/lst_front.sv */
// Front end: classifies each source byte, tracks the open token, builds token records.
module lst_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  lst_pkg::src_byte_t src,
    output lst_pkg::rec_t     rec,
    output logic              rec_vld
);

    lst_pkg::scan_mode_t       mode_reg, mode_next, mode_mid;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next, pos_inc;
    logic [23:0]               start_reg, start_next, start_mid;
    logic [15:0]               len_reg, len_next, len_mid, len_inc;
    logic [39:0]               prefix_reg, prefix_next, prefix_mid;
    logic [23:0]               pos24;
    logic [7:0]                c;
    logic                      is_alpha, is_digit, is_space, is_op;
    logic                      flush, open_new;

    // Classify the byte
    always_comb
    begin
        c        = src.ch;
        is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        is_digit = c inside {[8'h30:8'h39]};
        is_space = c inside {8'h20, [8'h09:8'h0D]};
        is_op    = c inside {lst_pkg::CH_PLUS, lst_pkg::CH_MINUS, lst_pkg::CH_SLASH,
                             lst_pkg::CH_STAR, lst_pkg::CH_AMP, lst_pkg::CH_BAR};
    end

    assign pos24   = 24'(pos_reg);
    assign pos_inc = pos_reg + POSITION_BITS'(1);
    assign len_inc = (len_reg == lst_pkg::LEN_MAX) ? len_reg : len_reg + 16'd1;

    // Close the open token on a byte that cannot extend it
    assign flush = (mode_reg == lst_pkg::MODE_WORD && !(is_alpha || is_digit)) ||
                   (mode_reg == lst_pkg::MODE_NUM && !is_digit && !is_alpha);
    assign open_new = (mode_reg == lst_pkg::MODE_IDLE) || flush;

    // Next state: mode and open token after this byte
    always_comb
    begin
        mode_mid   = mode_reg;
        start_mid  = start_reg;
        len_mid    = len_reg;
        prefix_mid = prefix_reg;
        case (mode_reg)
            lst_pkg::MODE_WORD:
            begin
                if (is_alpha || is_digit) begin
                    len_mid = len_inc;
                    if (len_reg < 16'd5) begin
                        prefix_mid = prefix_reg | (40'(c) << {len_reg[2:0], 3'b000});
                    end
                end
                else begin
                    mode_mid = lst_pkg::MODE_IDLE;
                end
            end
            lst_pkg::MODE_NUM:
            begin
                if (is_digit) begin
                    len_mid = len_inc;
                end
                else if (is_alpha) begin
                    len_mid  = len_inc;
                    mode_mid = lst_pkg::MODE_BAD;
                end
                else begin
                    mode_mid = lst_pkg::MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        if (open_new) begin
            if (is_space || c == lst_pkg::CH_LAMBDA || c == lst_pkg::CH_EQUAL || is_op) begin
            end
            else if (is_alpha) begin
                mode_mid   = lst_pkg::MODE_WORD;
                start_mid  = pos24;
                len_mid    = 16'd1;
                prefix_mid = 40'(c);
            end
            else if (is_digit) begin
                mode_mid   = lst_pkg::MODE_NUM;
                start_mid  = pos24;
                len_mid    = 16'd1;
                prefix_mid = '0;
            end
            else begin
                mode_mid = lst_pkg::MODE_BAD;
            end
        end
        // End of source returns everything to reset
        if (src.end_of_source) begin
            mode_next   = lst_pkg::MODE_IDLE;
            pos_next    = '0;
            start_next  = '0;
            len_next    = '0;
            prefix_next = '0;
        end
        else begin
            mode_next   = mode_mid;
            pos_next    = pos_inc;
            start_next  = start_mid;
            len_next    = len_mid;
            prefix_next = prefix_mid;
        end
    end

    // Outputs: tokens caused by this byte
    always_comb
    begin
        rec = '0;
        rec.a.token_kind = lst_pkg::TK_INVALID;
        rec.m.token_kind = lst_pkg::TK_INVALID;
        // Token closed by this byte
        case (mode_reg)
            lst_pkg::MODE_WORD:
            begin
                if (flush) begin
                    rec.a_vld = 1'b1;
                    rec.a     = '{lst_pkg::word_kind(len_reg, prefix_reg), start_reg, len_reg,
                                  8'h00};
                end
            end
            lst_pkg::MODE_NUM:
            begin
                if (flush) begin
                    rec.a_vld = 1'b1;
                    rec.a     = '{lst_pkg::TK_NAT, start_reg, len_reg, 8'h00};
                end
                else if (is_alpha) begin
                    rec.a_vld = 1'b1;
                    rec.a     = '{lst_pkg::TK_INVALID, start_reg, len_inc, 8'h00};
                end
            end
            default:
            begin
            end
        endcase
        // Single-byte token started by this byte
        if (open_new && !is_space && !is_alpha && !is_digit) begin
            rec.m_vld = 1'b1;
            if (c == lst_pkg::CH_LAMBDA) begin
                rec.m = '{lst_pkg::TK_LAMBDA, pos24, 16'd1, 8'h00};
            end
            else if (c == lst_pkg::CH_EQUAL) begin
                rec.m = '{lst_pkg::TK_EQUAL, pos24, 16'd1, 8'h00};
            end
            else if (is_op) begin
                rec.m = '{lst_pkg::TK_OP, pos24, 16'd1, c};
            end
            else begin
                rec.m = '{lst_pkg::TK_INVALID, pos24, 16'd1, 8'h00};
            end
        end
        // End of source: flush open token, then eof
        if (src.end_of_source) begin
            if (mode_mid == lst_pkg::MODE_WORD) begin
                rec.m_vld = 1'b1;
                rec.m     = '{lst_pkg::word_kind(len_mid, prefix_mid), start_mid, len_mid, 8'h00};
            end
            else if (mode_mid == lst_pkg::MODE_NUM) begin
                rec.m_vld = 1'b1;
                rec.m     = '{lst_pkg::TK_NAT, start_mid, len_mid, 8'h00};
            end
            rec.e_vld   = 1'b1;
            rec.e_start = 24'(pos_inc);
        end
        rec_vld = accept && (rec.a_vld || rec.m_vld || rec.e_vld);
    end

    // Hold scanner state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= lst_pkg::MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
        end
        else if (accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
        end
    end

    a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src.end_of_source |=> mode_reg == lst_pkg::MODE_IDLE && pos_reg == '0)
        else $error("scanner not reset after end of source");

    a_bad_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == lst_pkg::MODE_BAD && !src.end_of_source |-> !rec_vld)
        else $error("token produced in invalid mode");

    a_eos_eof: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src.end_of_source |-> rec_vld && rec.e_vld)
        else $error("end of source without eof record");

endmodule

/* rtl/core/lst_queue.sv */
// Short record queue that decouples the front end from the token emitter.
module lst_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  lst_pkg::rec_t din,
    input  logic          rd,
    output lst_pkg::rec_t dout,
    output logic          q_empty,
    output logic          q_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lst_pkg::rec_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign dout    = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store record
    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && q_full))
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && q_empty))
        else $error("record queue underflow");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr && !rd |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("record queue fill count wrong");

endmodule

/* rtl/core/lst_back.sv */
// Back end: walks each record's tokens in order into the output register.
module lst_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lst_pkg::rec_t  head,
    input  logic           head_vld,
    output logic           head_pop,
    input  logic           pop,
    output logic           empty,
    output lst_pkg::token_t tok
);

    lst_pkg::token_t   out_reg;
    logic              out_vld_reg, out_vld_next;
    logic              done_a_reg, done_a_next, done_m_reg, done_m_next;
    logic              rem_a, rem_m, rem_e, last, load;
    lst_pkg::tok_body_t body;

    assign rem_a = head.a_vld && !done_a_reg;
    assign rem_m = head.m_vld && !done_m_reg;
    assign rem_e = head.e_vld;

    // Pick the oldest token still waiting in the head record
    always_comb
    begin
        if (rem_a) begin
            body = head.a;
            last = !rem_m && !rem_e;
        end
        else if (rem_m) begin
            body = head.m;
            last = !rem_e;
        end
        else begin
            body = '{lst_pkg::TK_EOF, head.e_start, 16'd0, 8'h00};
            last = 1'b1;
        end
    end

    // Load when the output register is free or being drained
    assign load     = head_vld && (!out_vld_reg || pop);
    assign head_pop = load && last;

    always_comb
    begin
        done_a_next  = done_a_reg;
        done_m_next  = done_m_reg;
        out_vld_next = out_vld_reg;
        if (load) begin
            out_vld_next = 1'b1;
            if (last) begin
                done_a_next = 1'b0;
                done_m_next = 1'b0;
            end
            else if (rem_a) begin
                done_a_next = 1'b1;
            end
            else begin
                done_m_next = 1'b1;
            end
        end
        else if (pop) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
            done_a_reg  <= 1'b0;
            done_m_reg  <= 1'b0;
        end
        else begin
            out_vld_reg <= out_vld_next;
            done_a_reg  <= done_a_next;
            done_m_reg  <= done_m_next;
        end
    end

    // Hold the presented transaction until taken
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= '{body.token_kind, body.token_start, body.token_length, body.op_char,
                         last};
        end
    end

    assign empty = !out_vld_reg;
    assign tok   = out_reg;

endmodule

/* rtl/core/lambda_source_tokenizer_core.sv */
// Top level of the byte-serial source tokenizer.
//
//   channel  | ports                   | moves
//   ---------+-------------------------+----------------------------------------
//   source   | push, full, src         | one source byte and end-of-source mark
//   tokens   | empty, pop, tok         | one token: kind, start, length, op, last
//
// A byte is accepted in any cycle that the record queue is not full, one per cycle.
// Each byte yields zero to three tokens; the emitter delivers one token per cycle while
// tok is popped, so a byte with several tokens holds the back end and the record queue
// (QUEUE_DEPTH entries) absorbs the difference. A token passes the record queue, then
// the output register. Reset clears scanner mode, position and queue pointers at once.
module lambda_source_tokenizer_core #(
    parameter int POSITION_BITS = 24,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lst_pkg::src_byte_t src,
    output logic               empty,
    input  logic               pop,
    output lst_pkg::token_t    tok
);

    logic          accept, rec_vld, q_empty, q_full, q_rd;
    lst_pkg::rec_t rec, head;

    assign full   = q_full;
    assign accept = push && !q_full;

    lst_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .src     (src),
        .rec     (rec),
        .rec_vld (rec_vld)
    );

    lst_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rec_vld),
        .din     (rec),
        .rd      (q_rd),
        .dout    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    lst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_vld (!q_empty),
        .head_pop (q_rd),
        .pop      (pop),
        .empty    (empty),
        .tok      (tok)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the byte-serial source tokenizer core.
module testbench;

    // One row of the directed table; typed rows carry their single token
    typedef struct packed {
        logic [7:0]           ch;
        logic                 eos;
        logic                 typed;
        lst_pkg::token_kind_t kind;
        logic [23:0]          start;
        logic [15:0]          len;
        logic [7:0]           opc;
    } dir_row_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               pop   = 1'b0;
    lst_pkg::src_byte_t src   = '0;
    logic               full;
    logic               empty;
    lst_pkg::token_t    tok;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int fails        = 0;
    int sent         = 0;

    // Mirror of the scanner state
    lst_pkg::scan_mode_t lx_mode;
    logic [23:0]         lx_pos;
    logic [23:0]         lx_start;
    logic [15:0]         lx_len;
    logic [39:0]         lx_prefix;

    lst_pkg::token_t    step_toks[$];
    lst_pkg::token_t    tok_q[$];
    lst_pkg::src_byte_t stim_q[$];
    dir_row_t           dir_tab[21];
    lst_pkg::token_t    exp_tok;

    always #1 clk = ~clk;

    lambda_source_tokenizer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .src   (src),
        .empty (empty),
        .pop   (pop),
        .tok   (tok)
    );

    // Character classes
    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_operator(input logic [7:0] c);
        return c == lst_pkg::CH_PLUS || c == lst_pkg::CH_MINUS || c == lst_pkg::CH_SLASH ||
               c == lst_pkg::CH_STAR || c == lst_pkg::CH_AMP || c == lst_pkg::CH_BAR;
    endfunction

    function void reset_lexer();
        lx_mode   = lst_pkg::MODE_IDLE;
        lx_pos    = '0;
        lx_start  = '0;
        lx_len    = '0;
        lx_prefix = '0;
    endfunction

    function void emit(input lst_pkg::token_kind_t k, input logic [23:0] s,
                       input logic [15:0] l, input logic [7:0] o);
        step_toks.push_back(lst_pkg::token_t'{k, s, l, o, 1'b0});
    endfunction

    // Saturating length count
    function void lengthen();
        if (lx_len != lst_pkg::LEN_MAX)
            lx_len = lx_len + 16'd1;
    endfunction

    function lst_pkg::token_kind_t classify_word();
        if (lx_len == 16'd2 && lx_prefix == lst_pkg::KW_IF)
            return lst_pkg::TK_IF;
        if (lx_len == 16'd4 && lx_prefix == lst_pkg::KW_THEN)
            return lst_pkg::TK_THEN;
        if (lx_len == 16'd4 && lx_prefix == lst_pkg::KW_ELSE)
            return lst_pkg::TK_ELSE;
        if (lx_len == 16'd4 && lx_prefix == lst_pkg::KW_TRUE)
            return lst_pkg::TK_BOOL;
        if (lx_len == 16'd5 && lx_prefix == lst_pkg::KW_FALSE)
            return lst_pkg::TK_BOOL;
        return lst_pkg::TK_VARIABLE;
    endfunction

    // Emit the open word or number; invalid mode stays sticky
    function void close_token();
        if (lx_mode == lst_pkg::MODE_WORD)
            emit(classify_word(), lx_start, lx_len, 8'd0);
        else if (lx_mode == lst_pkg::MODE_NUM)
            emit(lst_pkg::TK_NAT, lx_start, lx_len, 8'd0);
        if (lx_mode != lst_pkg::MODE_BAD)
            lx_mode = lst_pkg::MODE_IDLE;
    endfunction

    // Work out the tokens one source byte causes
    function void predict_tokens(input lst_pkg::src_byte_t b);
        logic [7:0]      c;
        logic [23:0]     p;
        lst_pkg::token_t t;
        c = b.ch;
        p = lx_pos;
        step_toks.delete();

        // Extend or close an open token
        if (lx_mode == lst_pkg::MODE_WORD)
        begin
            if (is_letter(c) || is_numeral(c))
            begin
                if (lx_len < 16'd5)
                    lx_prefix = lx_prefix | (40'(c) << (8 * lx_len));
                lengthen();
            end
            else
                close_token();
        end
        else if (lx_mode == lst_pkg::MODE_NUM)
        begin
            if (is_numeral(c))
                lengthen();
            else if (is_letter(c))
            begin
                lengthen();
                emit(lst_pkg::TK_INVALID, lx_start, lx_len, 8'd0);
                lx_mode = lst_pkg::MODE_BAD;
            end
            else
                close_token();
        end

        // Start a new token between tokens
        if (lx_mode == lst_pkg::MODE_IDLE)
        begin
            if (c == lst_pkg::CH_LAMBDA)
                emit(lst_pkg::TK_LAMBDA, p, 16'd1, 8'd0);
            else if (c == lst_pkg::CH_EQUAL)
                emit(lst_pkg::TK_EQUAL, p, 16'd1, 8'd0);
            else if (is_operator(c))
                emit(lst_pkg::TK_OP, p, 16'd1, c);
            else if (is_letter(c))
            begin
                lx_mode   = lst_pkg::MODE_WORD;
                lx_start  = p;
                lx_len    = 16'd1;
                lx_prefix = 40'(c);
            end
            else if (is_numeral(c))
            begin
                lx_mode   = lst_pkg::MODE_NUM;
                lx_start  = p;
                lx_len    = 16'd1;
                lx_prefix = '0;
            end
            else if (!is_blank(c))
            begin
                emit(lst_pkg::TK_INVALID, p, 16'd1, 8'd0);
                lx_mode = lst_pkg::MODE_BAD;
            end
        end

        lx_pos = p + 24'd1;

        // Flush and close the source
        if (b.end_of_source)
        begin
            close_token();
            emit(lst_pkg::TK_EOF, lx_pos, 16'd0, 8'd0);
            reset_lexer();
        end

        // Mark the last token of this byte
        if (step_toks.size() > 0)
        begin
            t = step_toks.pop_back();
            t.run_last = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // Random source text
    function void add_byte(input logic [7:0] c);
        stim_q.push_back(lst_pkg::src_byte_t'{c, 1'b0});
    endfunction

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
            return 8'h41 + 8'($urandom_range(25));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function logic [7:0] rand_numeral();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function logic [7:0] rand_blank();
        if ($urandom_range(1) == 0)
            return 8'd32;
        return 8'd9 + 8'($urandom_range(4));
    endfunction

    // Build one source: mostly well-formed tokens, some noise
    function void build_source();
        int                 n;
        lst_pkg::src_byte_t t;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                stim_q.push_back(lst_pkg::src_byte_t'{8'($urandom_range(255)),
                                                      1'($urandom_range(1))});
            return;
        end
        n = $urandom_range(1, 10);
        repeat (n)
        begin
            case ($urandom_range(11))
                0, 1, 2:
                begin
                    case ($urandom_range(4))
                        0: add_text("if");
                        1: add_text("then");
                        2: add_text("else");
                        3: add_text("true");
                        default: add_text("false");
                    endcase
                end
                3:
                begin
                    case ($urandom_range(7))
                        0: add_text("iff");
                        1: add_text("the");
                        2: add_text("els");
                        3: add_text("tru");
                        4: add_text("falses");
                        5: add_text("If");
                        6: add_text("TRUE");
                        default: add_text("fals");
                    endcase
                end
                4, 5:
                begin
                    add_byte(rand_letter());
                    repeat ($urandom_range(0, 6))
                        add_byte($urandom_range(3) == 0 ? rand_numeral() : rand_letter());
                end
                6, 7:
                begin
                    repeat ($urandom_range(1, 6))
                        add_byte(rand_numeral());
                end
                8:
                begin
                    case ($urandom_range(5))
                        0: add_byte(lst_pkg::CH_PLUS);
                        1: add_byte(lst_pkg::CH_MINUS);
                        2: add_byte(lst_pkg::CH_SLASH);
                        3: add_byte(lst_pkg::CH_STAR);
                        4: add_byte(lst_pkg::CH_AMP);
                        default: add_byte(lst_pkg::CH_BAR);
                    endcase
                end
                9:
                    add_byte($urandom_range(1) == 0 ? lst_pkg::CH_LAMBDA : lst_pkg::CH_EQUAL);
                10:
                begin
                    repeat ($urandom_range(1, 3))
                        add_byte(rand_blank());
                end
                default:
                begin
                    // Letter inside a number, or any byte at all
                    if ($urandom_range(1) == 0)
                    begin
                        add_byte(rand_numeral());
                        add_byte(rand_letter());
                    end
                    else
                        add_byte(8'($urandom_range(255)));
                end
            endcase
            if ($urandom_range(9) < 6)
                add_byte(rand_blank());
        end
        t = stim_q.pop_back();
        t.end_of_source = 1'b1;
        stim_q.push_back(t);
    endfunction

    // Offer one byte, hold it until accepted, then record its tokens
    task automatic send_byte(input lst_pkg::src_byte_t b, input bit typed,
                             input lst_pkg::token_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        src  <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tokens(b);
        if (typed)
            tok_q.push_back(want);
        else
            foreach (step_toks[i])
                tok_q.push_back(step_toks[i]);
        sent++;
        @(negedge clk);
    endtask

    function void check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Drive pop with random stalls
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_gap_pct);

    // Compare each token transaction with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (tok_q.size() == 0)
            begin
                $error("token with nothing expected: kind %0d, start %0d",
                       tok.token_kind, tok.token_start);
                fails++;
            end
            else
            begin
                exp_tok = tok_q.pop_front();
                check_field("token_kind", 24'(exp_tok.token_kind), 24'(tok.token_kind));
                check_field("token_start", exp_tok.token_start, tok.token_start);
                check_field("token_length", 24'(exp_tok.token_length),
                            24'(tok.token_length));
                check_field("op_char", 24'(exp_tok.op_char), 24'(tok.op_char));
                check_field("run_last", 24'(exp_tok.run_last), 24'(tok.run_last));
            end
        end
    end

    // Stimulus
    initial
    begin
        lst_pkg::token_t want;
        reset_lexer();

        // Punctuation, NUL and a high byte; invalid mode swallows the rest
        dir_tab[0]  = '{lst_pkg::CH_LAMBDA, 1'b0, 1'b1, lst_pkg::TK_LAMBDA,  24'd0, 16'd1, 8'd0};
        dir_tab[1]  = '{lst_pkg::CH_EQUAL,  1'b0, 1'b1, lst_pkg::TK_EQUAL,   24'd1, 16'd1, 8'd0};
        dir_tab[2]  = '{lst_pkg::CH_BAR,    1'b0, 1'b1, lst_pkg::TK_OP,      24'd2, 16'd1,
                        lst_pkg::CH_BAR};
        dir_tab[3]  = '{8'h00,              1'b0, 1'b1, lst_pkg::TK_INVALID, 24'd3, 16'd1, 8'd0};
        dir_tab[4]  = '{"a",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[5]  = '{8'hFF,              1'b1, 1'b1, lst_pkg::TK_EOF,     24'd6, 16'd0, 8'd0};
        // Keyword, operator, number closed by a blank, letter inside a number
        dir_tab[6]  = '{"i",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[7]  = '{"f",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[8]  = '{lst_pkg::CH_PLUS,   1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[9]  = '{"4",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[10] = '{"2",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[11] = '{8'd32,              1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[12] = '{"7",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[13] = '{"q",                1'b1, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        // Keyword closed by a tab, number flushed by the end of the source
        dir_tab[14] = '{"e",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[15] = '{"l",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[16] = '{"s",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[17] = '{"e",                1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[18] = '{8'd9,               1'b0, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        dir_tab[19] = '{"9",                1'b1, 1'b0, lst_pkg::TK_EOF,     24'd0, 16'd0, 8'd0};
        // Source of a single blank
        dir_tab[20] = '{8'd13,              1'b1, 1'b1, lst_pkg::TK_EOF,     24'd1, 16'd0, 8'd0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 17;
        recv_gap_pct = 58;
        foreach (dir_tab[i])
        begin
            want = lst_pkg::token_t'{dir_tab[i].kind, dir_tab[i].start, dir_tab[i].len,
                                     dir_tab[i].opc, 1'b1};
            send_byte(lst_pkg::src_byte_t'{dir_tab[i].ch, dir_tab[i].eos}, dir_tab[i].typed,
                      want);
        end

        // Random sources under three idling patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 17;
                    recv_gap_pct = 58;
                end
                1:
                begin
                    send_gap_pct = 58;
                    recv_gap_pct = 17;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            while (sent < 21 + 60 * (ph + 1))
            begin
                build_source();
                while (stim_q.size() > 0)
                    send_byte(stim_q.pop_front(), 1'b0, '0);
            end
        end
        push <= 1'b0;

        // Drain and let any stray token show up
        while (tok_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lst_pkg.sv
rtl/core/lst_front.sv
rtl/core/lst_queue.sv
rtl/core/lst_back.sv
rtl/core/lambda_source_tokenizer_core.sv
bench/testbench.sv
